### rtl/vebs_pkg.sv
// Package for the variable-edge bin search block.
// Holds the command and status codes, the sequencer states and the result record.
// Has no dependencies; the sequencer and the top level refer to it by scoped names.
package vebs_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_LOOKUP = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        STAT_OK             = 3'd0,
        STAT_NOT_INCREASING = 3'd1,
        STAT_FULL           = 3'd2,
        STAT_TOO_FEW        = 3'd3,
        STAT_OUT_OF_RANGE   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPEND_RD,
        ST_APPEND_CMP,
        ST_APPEND_WR,
        ST_FIRST_RD,
        ST_FIRST_CMP,
        ST_LAST_RD,
        ST_LAST_CMP,
        ST_MID_RD,
        ST_MID_CMP,
        ST_DONE
    } state_t;

    localparam int BIN_W   = 6;
    localparam int COUNT_W = 7;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic               found;
        status_t            status;
        logic [COUNT_W-1:0] edges_held;
    } result_t;

endpackage

### rtl/vebs_edge_mem.sv
// Edge table storage: a single-port-write, single-port-read memory.
// The read data is registered; no reset is applied to the contents.
// Depends on nothing else in the project.
module vebs_edge_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = 6
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/vebs_ctrl.sv
// Sequencer for the bin search: dispatches commands, drives the edge memory
// and runs the binary search through one shared key comparator.
// Depends on vebs_pkg.
module vebs_ctrl #(
    parameter int MAX_EDGES  = 64,
    parameter int VALUE_BITS = 32,
    parameter int AW         = 6,
    parameter int CW         = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_command,
    input  logic [31:0]           in_value,
    output logic                  res_valid,
    input  logic                  res_ready,
    output vebs_pkg::result_t     res,
    output logic                  mem_we,
    output logic [AW-1:0]         mem_waddr,
    output logic [VALUE_BITS-1:0] mem_wdata,
    output logic [AW-1:0]         mem_raddr,
    input  logic [VALUE_BITS-1:0] mem_rdata
);

    vebs_pkg::state_t         state_reg, state_next;
    vebs_pkg::status_t        status_reg, status_next;
    logic [VALUE_BITS-1:0]    key_reg, key_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [AW-1:0]            lo_reg, lo_next;
    logic [AW-1:0]            hi_reg, hi_next;
    logic [AW-1:0]            bin_reg, bin_next;
    logic                     found_reg, found_next;

    logic [VALUE_BITS+31:0]   value_wide;
    logic [VALUE_BITS-1:0]    in_key;
    logic [CW-1:0]            count_m1;
    logic [AW:0]              mid_sum;
    logic [AW-1:0]            mid;
    logic [AW-1:0]            new_lo;
    logic [AW-1:0]            new_hi;
    logic [AW:0]              span;
    logic                     key_lt;
    logic                     key_eq;
    logic                     key_gt;
    logic [CW+vebs_pkg::COUNT_W-1:0] count_wide;
    logic [AW+vebs_pkg::BIN_W-1:0]   bin_wide;

    // Keys are offset binary (sign bit inverted) so that an unsigned compare
    // orders them as the signed values.
    assign value_wide = {{VALUE_BITS{in_value[31]}}, in_value};
    assign in_key     = {~value_wide[VALUE_BITS-1], value_wide[VALUE_BITS-2:0]};

    // The one comparator, shared by the append check and every compare step of a lookup.
    assign key_lt = key_reg < mem_rdata;
    assign key_eq = key_reg == mem_rdata;
    assign key_gt = !key_lt && !key_eq;

    assign count_m1 = count_reg - CW'(1);
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[AW:1];
    assign new_lo   = key_lt ? lo_reg : mid;
    assign new_hi   = key_lt ? mid : hi_reg;
    assign span     = {1'b0, new_hi} - {1'b0, new_lo};

    assign count_wide = {{vebs_pkg::COUNT_W{1'b0}}, count_reg};
    assign bin_wide   = {{vebs_pkg::BIN_W{1'b0}}, bin_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vebs_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        status_reg <= status_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        bin_reg    <= bin_next;
        found_reg  <= found_next;
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        bin_next    = bin_reg;
        found_next  = found_reg;
        in_ready    = 1'b0;
        res_valid   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = count_reg[AW-1:0];
        mem_wdata   = key_reg;
        mem_raddr   = count_m1[AW-1:0];

        case (state_reg)
            vebs_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    key_next    = in_key;
                    status_next = vebs_pkg::STAT_OK;
                    found_next  = 1'b0;
                    bin_next    = '0;
                    case (vebs_pkg::cmd_t'(in_command))
                        vebs_pkg::CMD_CLEAR: begin
                            count_next = '0;
                            state_next = vebs_pkg::ST_DONE;
                        end
                        vebs_pkg::CMD_APPEND: begin
                            if (count_reg == CW'(MAX_EDGES)) begin
                                status_next = vebs_pkg::STAT_FULL;
                                state_next  = vebs_pkg::ST_DONE;
                            end else if (count_reg == '0) begin
                                state_next = vebs_pkg::ST_APPEND_WR;
                            end else begin
                                state_next = vebs_pkg::ST_APPEND_RD;
                            end
                        end
                        vebs_pkg::CMD_LOOKUP: begin
                            if (count_reg < CW'(2)) begin
                                status_next = vebs_pkg::STAT_TOO_FEW;
                                state_next  = vebs_pkg::ST_DONE;
                            end else begin
                                state_next = vebs_pkg::ST_FIRST_RD;
                            end
                        end
                        default: begin
                            state_next = vebs_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            vebs_pkg::ST_APPEND_RD: begin
                state_next = vebs_pkg::ST_APPEND_CMP;
            end
            vebs_pkg::ST_APPEND_CMP: begin
                if (key_gt) begin
                    state_next = vebs_pkg::ST_APPEND_WR;
                end else begin
                    status_next = vebs_pkg::STAT_NOT_INCREASING;
                    state_next  = vebs_pkg::ST_DONE;
                end
            end
            vebs_pkg::ST_APPEND_WR: begin
                mem_we     = 1'b1;
                count_next = count_reg + CW'(1);
                state_next = vebs_pkg::ST_DONE;
            end
            vebs_pkg::ST_FIRST_RD: begin
                mem_raddr  = '0;
                state_next = vebs_pkg::ST_FIRST_CMP;
            end
            vebs_pkg::ST_FIRST_CMP: begin
                if (key_lt) begin
                    status_next = vebs_pkg::STAT_OUT_OF_RANGE;
                    state_next  = vebs_pkg::ST_DONE;
                end else begin
                    state_next = vebs_pkg::ST_LAST_RD;
                end
            end
            vebs_pkg::ST_LAST_RD: begin
                state_next = vebs_pkg::ST_LAST_CMP;
            end
            vebs_pkg::ST_LAST_CMP: begin
                if (!key_lt) begin
                    status_next = vebs_pkg::STAT_OUT_OF_RANGE;
                    state_next  = vebs_pkg::ST_DONE;
                end else begin
                    // The key now lies between the first and the last edge.
                    lo_next = '0;
                    hi_next = count_m1[AW-1:0];
                    if (count_reg > CW'(2)) begin
                        state_next = vebs_pkg::ST_MID_RD;
                    end else begin
                        found_next = 1'b1;
                        state_next = vebs_pkg::ST_DONE;
                    end
                end
            end
            vebs_pkg::ST_MID_RD: begin
                mem_raddr  = mid;
                state_next = vebs_pkg::ST_MID_CMP;
            end
            vebs_pkg::ST_MID_CMP: begin
                lo_next = new_lo;
                hi_next = new_hi;
                if (|span[AW:1]) begin
                    state_next = vebs_pkg::ST_MID_RD;
                end else begin
                    bin_next   = new_lo;
                    found_next = 1'b1;
                    state_next = vebs_pkg::ST_DONE;
                end
            end
            vebs_pkg::ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = vebs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vebs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.bin_index  = bin_wide[vebs_pkg::BIN_W-1:0];
        res.found      = found_reg;
        res.status     = status_reg;
        res.edges_held = count_wide[vebs_pkg::COUNT_W-1:0];
    end

endmodule

### rtl/variable_edge_bin_search.sv
// Variable-edge bin search: keeps strictly increasing bin edges and bins values.
// Clear, an unused command, an append to a full table and a lookup with fewer than two
// entries go straight to the result; an append compares against the last edge unless the table
// is empty, then writes; a lookup checks the first edge, then the last, then halves the range.
// A new command is taken only once the sequencer is idle again.
// Synchronous active-low reset empties the table; edge contents are not cleared.
module variable_edge_bin_search #(
    parameter int MAX_EDGES  = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic signed [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [5:0]  m_bin_index,
    output logic        m_found,
    output logic [2:0]  m_status,
    output logic [6:0]  m_edges_held
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;
    logic                  res_valid;
    logic                  res_ready;
    vebs_pkg::result_t     res;

    logic                  m_valid_reg, m_valid_next;
    vebs_pkg::result_t     out_reg, out_next;

    vebs_edge_mem #(
        .DEPTH (MAX_EDGES),
        .WIDTH (VALUE_BITS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    vebs_ctrl #(
        .MAX_EDGES  (MAX_EDGES),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW),
        .CW         (CW)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_command (s_command),
        .in_value   (s_value),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Output register: the sequencer may take a new transaction while a result waits.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_bin_index  = out_reg.bin_index;
    assign m_found      = out_reg.found;
    assign m_status     = out_reg.status;
    assign m_edges_held = out_reg.edges_held;

endmodule
